@@ hdl/srpl_pkg.sv @@
// ----------------------------------------------------------------------------
// srpl_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package srpl_pkg;

	// Default window depth (longest pattern)
	localparam int MAX_PATTERN_BYTES_DEF = 8;

	// A job carries at most eight result bytes
	localparam int JOB_BYTES = 8;
	localparam int JOB_IDX_W = $clog2(JOB_BYTES);

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_BYTES      = 3'd0,
		REG_PATTERN_LENGTH     = 3'd1,
		REG_REPLACEMENT_BYTES  = 3'd2,
		REG_REPLACEMENT_LENGTH = 3'd3,
		REG_MATCH_CASE         = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic [63:0] replacement_bytes;
		logic [3:0]  replacement_length;
		logic        match_case;
	} cfg_t;

	// One input item's worth of results, byte 0 emitted first
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] data;
		logic [JOB_IDX_W-1:0]      last_idx;   // number of results minus one
		logic                      byte_valid; // 0 for the end-only marker
		logic                      text_end;
	} job_t;

endpackage

@@ hdl/srpl_front.sv @@
// ----------------------------------------------------------------------------
// srpl_front
// Window, pattern compare, job build; one input per cycle unless queue full.
// ----------------------------------------------------------------------------
module srpl_front
	import srpl_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_final,
	input  logic       q_full,
	output logic       push,
	output job_t       job
);

	localparam int W     = MAX_PATTERN_BYTES;
	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0][7:0] win_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [W-1:0][7:0] wn;
	logic [W-1:0][7:0] win_shift;
	logic [CNT_W-1:0]  c, cp, len, e;
	logic [3:0]        rlen, job_n;
	logic              match, accept;

	function automatic logic [7:0] fold(input logic [7:0] ch, input logic exact);
		if (!exact && ch >= 8'h61 && ch <= 8'h7a)
			return ch - 8'd32;
		return ch;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		// clamp lengths
		if (cfg.pattern_length > 4'(W))
			len = CNT_W'(W);
		else
			len = cfg.pattern_length[CNT_W-1:0];
		rlen = (cfg.replacement_length > 4'd8) ? 4'd8 : cfg.replacement_length;

		c  = (cnt_q > CNT_W'(W - 1)) ? CNT_W'(W - 1) : cnt_q;
		cp = c + 1'b1;

		for (int i = 0; i < W; i++)
			wn[i] = (c == CNT_W'(i)) ? in_byte : win_q[i];

		match = (len != '0) && (cp == len);
		for (int i = 0; i < W; i++) begin
			if (CNT_W'(i) < len &&
			    fold(wn[i], cfg.match_case) !=
			    fold(cfg.pattern_bytes[8*i +: 8], cfg.match_case))
				match = 1'b0;
		end

		// bytes leaving the window when no match is taken
		if (len == '0)
			e = cp;
		else if (cp >= len)
			e = cp - len + 1'b1;
		else
			e = '0;

		win_shift = wn >> {e, 3'b000};

		job          = '0;
		job.text_end = in_final;
		job.byte_valid = 1'b1;
		if (match) begin
			job.data = cfg.replacement_bytes;
			job_n    = rlen;
			if (in_final && rlen == 4'd0) begin
				job.data       = '0;
				job.byte_valid = 1'b0;
				job_n          = 4'd1;
			end
		end else begin
			for (int i = 0; i < W; i++)
				job.data[i] = wn[i];
			job_n = in_final ? 4'(cp) : 4'(e);
		end
		job.last_idx = JOB_IDX_W'(job_n - 4'd1);
		push         = accept && (job_n != 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (match || in_final) begin
				win_q <= '0;
				cnt_q <= '0;
			end else begin
				win_q <= win_shift;
				cnt_q <= cp - e;
			end
		end
	end

endmodule

@@ hdl/srpl_queue.sv @@
// ----------------------------------------------------------------------------
// srpl_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module srpl_queue
	import srpl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hdl/srpl_back.sv @@
// ----------------------------------------------------------------------------
// srpl_back
// Unrolls a job into result transactions through an output register.
// ----------------------------------------------------------------------------
module srpl_back
	import srpl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  logic       head_valid,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       text_end
);

	logic [JOB_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 byte_valid_q, run_last_q, text_end_q;
	logic                 load, last;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign last = (idx_q == head.last_idx);
	assign pop  = load && last;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign text_end   = text_end_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.data[idx_q];
			byte_valid_q <= head.byte_valid;
			run_last_q   <= last;
			text_end_q   <= last && head.text_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/stream_replace_all.sv @@
// ----------------------------------------------------------------------------
// stream_replace_all
// Streaming find-and-replace-all over a byte text.
// ----------------------------------------------------------------------------
// Text bytes come in one per transaction on s_axis, tlast on the final byte
// of a text. Every leftmost, non-overlapping occurrence of the pattern
// (1..MAX_PATTERN_BYTES bytes, exact or ASCII case-folded compare) is
// replaced by the replacement (0..8 bytes); other bytes pass unchanged and
// in order. The front takes one input transaction per cycle whenever the
// four-entry job queue has room, so input and output stall independently.
// The back issues one result transaction per cycle from its output
// register while m_axis_tready allows, so an input byte that yields k
// results holds the back for k result transactions, a limit set by the
// single output port. Bytes are delayed while they may still start a match
// (up to pattern length minus one bytes). A final byte flushes the window;
// if a text ends with nothing left to emit (a match deleted by an empty
// replacement), one end-only result with tuser[0] low is sent. tlast on
// m_axis marks the end of the rewritten text. Configuration writes are
// accepted every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module stream_replace_all
	import srpl_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,

	// input text
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] text_byte
	input  logic                 s_axis_tlast,  // final_byte

	// rewritten text
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]           m_axis_tuser,  // [0] byte_valid, [1] run_last
	output logic                 m_axis_tlast   // text_end
);

	cfg_t cfg_q;
	job_t push_job, head;
	logic push, q_full, pop, head_valid;
	logic byte_valid, run_last;

	// Register bank: always ready, index out of range ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= '0;
			cfg_q.pattern_length     <= 4'd1;
			cfg_q.replacement_bytes  <= '0;
			cfg_q.replacement_length <= 4'd0;
			cfg_q.match_case         <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:      cfg_q.pattern_bytes      <= cfg_data;
				REG_PATTERN_LENGTH:     cfg_q.pattern_length     <= cfg_data[3:0];
				REG_REPLACEMENT_BYTES:  cfg_q.replacement_bytes  <= cfg_data;
				REG_REPLACEMENT_LENGTH: cfg_q.replacement_length <= cfg_data[3:0];
				REG_MATCH_CASE:         cfg_q.match_case         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: window update and match, builds at most one job per input transaction
	srpl_front #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_final (s_axis_tlast),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	srpl_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back: one result transaction per cycle while a job is queued and m_axis is ready
	srpl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.text_end   (m_axis_tlast)
	);

	assign m_axis_tuser = {run_last, byte_valid};

endmodule
